@@ src/aast_pkg.sv @@
// Package for the active alarm set table.
// Holds sizes, request codes and the structs passed between the top level and the slot cells.
// No dependencies.
`default_nettype none
package aast_pkg;

  localparam int CAPACITY  = 10;
  localparam int CODE_BITS = 16;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef logic [CODE_BITS-1:0] code_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic  load;       // a request is being accepted this cycle
    logic  append;     // add goes through and appends
    logic  remove;     // remove goes through
    logic  clear;
    code_t code;
  } cell_ctrl_t;

  // Passed from each cell to its right neighbor.
  typedef struct packed {
    logic hit;         // a match sits at or left of this point
    logic occ;         // the cell on the left is occupied
  } fwd_link_t;

  // Passed from each cell to its left neighbor.
  typedef struct packed {
    logic  occ;
    code_t code;
  } bwd_link_t;

endpackage
`default_nettype wire

@@ src/aast_cell.sv @@
// One slot of the alarm set: code, occupied flag, compare and shift logic.
// Depends on aast_pkg.
`default_nettype none
module aast_cell (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire aast_pkg::cell_ctrl_t   ctrl,
  input  wire aast_pkg::fwd_link_t    left_in,
  output aast_pkg::fwd_link_t         right_out,
  input  wire aast_pkg::bwd_link_t    right_in,
  output aast_pkg::bwd_link_t         left_out,
  output logic                        occ_flag
);

  aast_pkg::code_t slot;
  logic            occ;
  logic            match;
  logic            shift_in;
  logic            take_new;

  assign match     = occ && (slot == ctrl.code);
  assign right_out = '{hit: left_in.hit | match, occ: occ};
  assign left_out  = '{occ: occ, code: slot};
  assign occ_flag  = occ;
  assign shift_in  = ctrl.remove && (left_in.hit || match);
  assign take_new  = ctrl.append && !occ && left_in.occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= 1'b0;
      slot <= '0;
    end else if (ctrl.load) begin
      if (ctrl.clear) begin
        occ  <= 1'b0;
        slot <= '0;
      end else if (shift_in) begin
        occ  <= right_in.occ;
        slot <= right_in.code;
      end else if (take_new) begin
        occ  <= 1'b1;
        slot <= ctrl.code;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/active_alarm_set_table.sv @@
// Top level of the active alarm set table: request decode, count and output register.
// Instantiates a row of aast_cell slots; depends on aast_pkg.
//
//   channel   | dir | tdata                              | tuser
//   s_ (req)  | in  | [15:0] alarm_code                  | [1:0] req_type
//   m_ (res)  | out | [0] success, [4:1] alarm_count     | -
//
// One request per cycle while no result is stalled: the cells compare in parallel and shift by one in the same edge.
// The result is registered; a new request is taken while the held result is being read.
// Reset empties every slot and the count; no clearing pass is needed.
// A stalled result blocks further requests until it is taken.
`default_nettype none
module active_alarm_set_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] alarm_code
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // [0] success, [4:1] alarm_count, [7:5] zero
);

  localparam int N = aast_pkg::CAPACITY;
  localparam int W = aast_pkg::COUNT_W;

  aast_pkg::cell_ctrl_t ctrl;
  aast_pkg::fwd_link_t  fwd [N+1];
  aast_pkg::bwd_link_t  bwd [N+1];
  logic [N-1:0]         occ_vec;

  logic [W-1:0] count;
  logic [W-1:0] count_next;
  logic         full;
  logic         found;
  logic         accept;
  logic         ok;
  logic         success;
  logic [3:0]   count_out;

  assign accept = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign full   = count >= W'(N);

  assign fwd[0] = '{hit: 1'b0, occ: 1'b1};
  assign bwd[N] = '{occ: 1'b0, code: '0};
  assign found  = fwd[N].hit;

  assign ctrl.load   = accept;
  assign ctrl.code   = aast_pkg::CODE_BITS'(s_tdata);
  assign ctrl.append = (s_tuser == aast_pkg::REQ_ADD) && !full && !found;
  assign ctrl.remove = (s_tuser == aast_pkg::REQ_REMOVE) && found;
  assign ctrl.clear  = (s_tuser == aast_pkg::REQ_CLEAR);

  for (genvar i = 0; i < N; i++) begin : g_cell
    aast_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left_in   (fwd[i]),
      .right_out (fwd[i+1]),
      .right_in  (bwd[i+1]),
      .left_out  (bwd[i]),
      .occ_flag  (occ_vec[i])
    );
  end

  always_comb begin
    count_next = count;
    ok         = 1'b0;
    unique case (s_tuser)
      aast_pkg::REQ_ADD: begin
        ok = !full;
        if (ctrl.append) count_next = count + W'(1);
      end
      aast_pkg::REQ_REMOVE: begin
        ok = found;
        if (found) count_next = count - W'(1);
      end
      aast_pkg::REQ_QUERY: begin
        ok = found;
      end
      aast_pkg::REQ_CLEAR: begin
        ok         = 1'b1;
        count_next = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      success   <= ok;
      count_out <= 4'(count_next);
    end
  end

  assign m_tdata = {3'b000, count_out, success};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= W'(N))
    else $error("count above capacity");

  a_count_occ: assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == int'(count))
    else $error("count disagrees with occupied slots");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == aast_pkg::REQ_CLEAR |=>
      m_tvalid && m_tdata[0] && m_tdata[4:1] == 4'd0 && count == '0)
    else $error("clear request did not empty the table");

  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    !accept |=> count == $past(count))
    else $error("count moved without a request");
`endif

endmodule
`default_nettype wire

@@ tb/tb_active_alarm_set_table.sv @@
// Self-checking testbench for active_alarm_set_table: a short table of directed requests,
// then about a thousand random ones, each reply checked against the table or a predictor of the set.
// Depends on aast_pkg and the active_alarm_set_table RTL.
`default_nettype none
module tb_active_alarm_set_table;

  localparam int RANDOM_REQUESTS = 1000;
  localparam int CALM_TAIL       = 200;
  localparam int LONG_HOLD       = 60;

  typedef struct packed {
    logic       success;
    logic [3:0] count;
  } reply_t;

  typedef struct packed {
    logic [1:0]      kind;
    aast_pkg::code_t code;
    logic            typed;
    logic            ok;
    logic [3:0]      cnt;
  } step_t;

  localparam step_t DIRECTED [0:24] = '{
    '{aast_pkg::REQ_QUERY,  16'h0000, 1'b1, 1'b0, 4'd0},
    '{aast_pkg::REQ_REMOVE, 16'h0000, 1'b1, 1'b0, 4'd0},
    '{aast_pkg::REQ_ADD,    16'h0000, 1'b1, 1'b1, 4'd1},
    '{aast_pkg::REQ_ADD,    16'hFFFF, 1'b1, 1'b1, 4'd2},
    '{aast_pkg::REQ_ADD,    16'hFFFF, 1'b1, 1'b1, 4'd2},
    '{aast_pkg::REQ_QUERY,  16'hFFFF, 1'b1, 1'b1, 4'd2},
    '{aast_pkg::REQ_ADD,    16'h0001, 1'b1, 1'b1, 4'd3},
    '{aast_pkg::REQ_ADD,    16'h8000, 1'b1, 1'b1, 4'd4},
    '{aast_pkg::REQ_ADD,    16'h5555, 1'b1, 1'b1, 4'd5},
    '{aast_pkg::REQ_ADD,    16'hAAAA, 1'b1, 1'b1, 4'd6},
    '{aast_pkg::REQ_ADD,    16'h1234, 1'b1, 1'b1, 4'd7},
    '{aast_pkg::REQ_ADD,    16'h00FF, 1'b1, 1'b1, 4'd8},
    '{aast_pkg::REQ_ADD,    16'hFF00, 1'b1, 1'b1, 4'd9},
    '{aast_pkg::REQ_ADD,    16'h0F0F, 1'b1, 1'b1, 4'd10},
    '{aast_pkg::REQ_ADD,    16'hF0F0, 1'b1, 1'b0, 4'd10},
    '{aast_pkg::REQ_ADD,    16'hFFFF, 1'b1, 1'b0, 4'd10},
    '{aast_pkg::REQ_QUERY,  16'h0000, 1'b1, 1'b1, 4'd10},
    '{aast_pkg::REQ_REMOVE, 16'h0001, 1'b0, 1'b0, 4'd0},
    '{aast_pkg::REQ_QUERY,  16'h0001, 1'b0, 1'b0, 4'd0},
    '{aast_pkg::REQ_REMOVE, 16'h0F0F, 1'b0, 1'b0, 4'd0},
    '{aast_pkg::REQ_REMOVE, 16'h0000, 1'b0, 1'b0, 4'd0},
    '{aast_pkg::REQ_REMOVE, 16'h7777, 1'b0, 1'b0, 4'd0},
    '{aast_pkg::REQ_ADD,    16'h0F0F, 1'b0, 1'b0, 4'd0},
    '{aast_pkg::REQ_CLEAR,  16'hBEEF, 1'b1, 1'b1, 4'd0},
    '{aast_pkg::REQ_QUERY,  16'hFFFF, 1'b1, 1'b0, 4'd0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  aast_pkg::code_t held_codes [aast_pkg::CAPACITY];
  int              held_total;
  aast_pkg::code_t code_pool [12];
  reply_t          pending_replies [$];
  int              fail_count;
  int              replies_seen;
  bit              calm_tail;

  active_alarm_set_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic reply_t apply_request(logic [1:0] kind, aast_pkg::code_t code);
    reply_t r;
    int     pos;
    r.success = 1'b0;
    pos = -1;
    for (int i = 0; i < held_total; i++)
      if (pos < 0 && held_codes[i] == code) pos = i;
    case (kind)
      aast_pkg::REQ_ADD: begin
        if (held_total >= aast_pkg::CAPACITY) begin
          r.success = 1'b0;
        end else if (pos >= 0) begin
          r.success = 1'b1;
        end else begin
          held_codes[held_total] = code;
          held_total++;
          r.success = 1'b1;
        end
      end
      aast_pkg::REQ_REMOVE: begin
        if (pos >= 0) begin
          for (int j = pos; j < held_total - 1; j++) held_codes[j] = held_codes[j + 1];
          held_total--;
          held_codes[held_total] = '0;
          r.success = 1'b1;
        end
      end
      aast_pkg::REQ_QUERY: begin
        r.success = (pos >= 0);
      end
      default: begin
        for (int j = 0; j < aast_pkg::CAPACITY; j++) held_codes[j] = '0;
        held_total = 0;
        r.success = 1'b1;
      end
    endcase
    r.count = held_total[3:0];
    return r;
  endfunction

  function automatic aast_pkg::code_t pick_code();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && held_total > 0) return held_codes[$urandom_range(0, held_total - 1)];
    if (roll < 8) return code_pool[$urandom_range(0, 11)];
    return aast_pkg::code_t'($urandom);
  endfunction

  function automatic logic [1:0] pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 42) return aast_pkg::REQ_ADD;
    if (roll < 72) return aast_pkg::REQ_REMOVE;
    if (roll < 97) return aast_pkg::REQ_QUERY;
    return aast_pkg::REQ_CLEAR;
  endfunction

  task automatic offer_request(input logic [1:0] kind, input aast_pkg::code_t code,
                               input logic typed, input logic ok, input logic [3:0] cnt);
    int     gap;
    reply_t predicted;
    gap = 0;
    if (!calm_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= code;
    do @(posedge clk); while (!s_tready);
    predicted = apply_request(kind, code);
    if (typed) begin
      predicted.success = ok;
      predicted.count   = cnt;
    end
    pending_replies.push_back(predicted);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      replies_seen <= replies_seen + 1;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, actual success=%0b count=%0d",
                 $time, m_tdata[0], m_tdata[4:1]);
        fail_count++;
      end else begin
        reply_t want;
        want = pending_replies.pop_front();
        if (m_tdata[0] !== want.success) begin
          $display("%0t: success mismatch, expected %0b actual %0b",
                   $time, want.success, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[4:1] !== want.count) begin
          $display("%0t: alarm_count mismatch, expected %0d actual %0d",
                   $time, want.count, m_tdata[4:1]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    bit held_long;
    held_long = 1'b0;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!held_long && replies_seen >= 300) begin
        held_long = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = aast_pkg::REQ_QUERY;
    fail_count = 0;
    replies_seen = 0;
    calm_tail = 1'b0;
    held_total = 0;
    for (int i = 0; i < aast_pkg::CAPACITY; i++) held_codes[i] = '0;
    code_pool[0] = 16'h0000;
    code_pool[1] = 16'hFFFF;
    for (int i = 2; i < 12; i++) code_pool[i] = aast_pkg::code_t'($urandom);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      offer_request(DIRECTED[i].kind, DIRECTED[i].code, DIRECTED[i].typed,
                    DIRECTED[i].ok, DIRECTED[i].cnt);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      logic [1:0]      kind;
      aast_pkg::code_t code;
      if (n >= RANDOM_REQUESTS - CALM_TAIL) calm_tail = 1'b1;
      kind = pick_kind();
      code = pick_code();
      offer_request(kind, code, 1'b0, 1'b0, 4'd0);
    end
    s_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
src/aast_pkg.sv
src/aast_cell.sv
src/active_alarm_set_table.sv
tb/tb_active_alarm_set_table.sv
